@@ sv/dbp_pkg.sv @@
// Shared types and constants for the depth-to-point back-projection block.
// Holds register indexes, reset values, controller states and the
// command/status structs between controller and datapath.
package dbp_pkg;

  localparam int MAX_DIMENSION_DEF = 4096;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_METRES_PER_UNIT = 3'd6;

  localparam logic [12:0] RST_IMAGE_COLS      = 13'd640;
  localparam logic [12:0] RST_IMAGE_ROWS      = 13'd480;
  localparam logic [15:0] RST_CENTER_X        = 16'd5208;
  localparam logic [15:0] RST_CENTER_Y        = 16'd3768;
  localparam logic [23:0] RST_INV_FOCAL_X     = 24'd32388;
  localparam logic [23:0] RST_INV_FOCAL_Y     = 24'd32326;
  localparam logic [23:0] RST_METRES_PER_UNIT = 24'd16777;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ROUND,
    S_PROD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;   // latch input item, advance position counters
    logic mul;       // depth scale and centred-offset products
    logic round;     // round z and the offset terms
    logic prod;      // offset term times z
    logic load_out;  // round, saturate, load output register
  } cmd_t;

  typedef struct packed {
    logic out_free;  // output register empty or being taken this cycle
  } status_t;

endpackage

@@ sv/dbp_ctrl.sv @@
// Sequencer for the back-projection datapath: walks one item through
// capture, multiply, round, multiply and output load. Uses dbp_pkg.
module dbp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  dbp_pkg::status_t status,
  output dbp_pkg::cmd_t    cmd
);
  import dbp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_PROD;
      end
      S_PROD: begin
        cmd.prod   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // hold until the output register can take the item
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ sv/dbp_datapath.sv @@
// Datapath for depth-to-point back-projection: position counters, the
// multiply/round stages and the output register. Uses dbp_pkg.
module dbp_datapath #(
  parameter int MAX_DIMENSION = dbp_pkg::MAX_DIMENSION_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dbp_pkg::cmd_t       cmd,
  output dbp_pkg::status_t    status,
  input  logic [15:0]         depth_raw,
  input  logic [7:0]          blue,
  input  logic [7:0]          green,
  input  logic [7:0]          red,
  input  logic [12:0]         image_cols,
  input  logic [12:0]         image_rows,
  input  logic [15:0]         center_x_q4,
  input  logic [15:0]         center_y_q4,
  input  logic [23:0]         inv_focal_x_q24,
  input  logic [23:0]         inv_focal_y_q24,
  input  logic [23:0]         metres_per_unit_q24,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                point_valid,
  output logic                frame_end,
  output logic signed [31:0]  x_q16,
  output logic signed [31:0]  y_q16,
  output logic [31:0]         z_q16,
  output logic [7:0]          point_blue,
  output logic [7:0]          point_green,
  output logic [7:0]          point_red
);
  import dbp_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIMENSION);
  localparam int D_W   = (CNT_W + 4 > 16) ? CNT_W + 4 : 16;
  localparam int N_W   = D_W + 24;     // |offset| * inverse focal, Q28
  localparam int N16_W = N_W - 11;     // rounded to Q16
  localparam int M_W   = N16_W + 32;   // times z, Q32
  localparam int MAG_W = M_W - 15;     // rounded to Q16

  // Last valid index for a size register, after clamping to 1..MAX_DIMENSION.
  function automatic logic [CNT_W-1:0] dim_limit(input logic [12:0] v);
    logic [31:0] lim;
    if (v == 13'd0) begin
      lim = 32'd0;
    end else if (32'(v) > 32'(MAX_DIMENSION)) begin
      lim = 32'(MAX_DIMENSION - 1);
    end else begin
      lim = 32'(v) - 32'd1;
    end
    return lim[CNT_W-1:0];
  endfunction

  // Saturate a rounded magnitude and apply the sign.
  function automatic logic [31:0] sat_axis(input logic [MAG_W-1:0] mag, input logic neg);
    logic [31:0] res;
    if (neg) begin
      if (mag > MAG_W'(64'h8000_0000)) begin
        res = 32'h8000_0000;
      end else begin
        res = 32'd0 - mag[31:0];
      end
    end else begin
      if (mag > MAG_W'(64'h7FFF_FFFF)) begin
        res = 32'h7FFF_FFFF;
      end else begin
        res = mag[31:0];
      end
    end
    return res;
  endfunction

  logic [CNT_W-1:0] col_cnt, row_cnt;
  logic [CNT_W-1:0] col_lim, row_lim;
  logic             row_last, frame_last;

  logic [15:0]      depth_q;
  logic [7:0]       blue_q, green_q, red_q;
  logic [CNT_W-1:0] col_q, row_q;
  logic             flast_q;

  logic [D_W-1:0]   px16, py16, cx, cy, magx, magy;
  logic             negx_c, negy_c;
  logic             negx, negy;
  logic [39:0]      zfull;
  logic [N_W-1:0]   nx, ny;
  logic [N_W:0]     nx_rnd, ny_rnd;
  logic [40:0]      z_rnd;
  logic [31:0]      z;
  logic [N16_W-1:0] n16x, n16y;
  logic [M_W-1:0]   mx, my;
  logic [M_W:0]     mx_rnd, my_rnd;
  logic             has_depth;

  assign col_lim    = dim_limit(image_cols);
  assign row_lim    = dim_limit(image_rows);
  assign row_last   = col_cnt >= col_lim;
  assign frame_last = row_last && (row_cnt >= row_lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (cmd.capture) begin
      if (row_last) begin
        col_cnt <= '0;
        row_cnt <= frame_last ? '0 : row_cnt + 1'b1;
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      depth_q <= depth_raw;
      blue_q  <= blue;
      green_q <= green;
      red_q   <= red;
      col_q   <= col_cnt;
      row_q   <= row_cnt;
      flast_q <= frame_last;
    end
  end

  // centred position in sixteenths of a pixel, split into sign and magnitude
  assign px16   = D_W'({col_q, 4'b0000});
  assign py16   = D_W'({row_q, 4'b0000});
  assign cx     = D_W'(center_x_q4);
  assign cy     = D_W'(center_y_q4);
  assign negx_c = px16 < cx;
  assign negy_c = py16 < cy;
  assign magx   = negx_c ? cx - px16 : px16 - cx;
  assign magy   = negy_c ? cy - py16 : py16 - cy;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      zfull <= depth_q * metres_per_unit_q24;
      nx    <= magx * inv_focal_x_q24;
      ny    <= magy * inv_focal_y_q24;
      negx  <= negx_c;
      negy  <= negy_c;
    end
  end

  assign z_rnd  = {1'b0, zfull} + 41'd128;
  assign nx_rnd = {1'b0, nx} + (N_W+1)'(2048);
  assign ny_rnd = {1'b0, ny} + (N_W+1)'(2048);

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      z    <= z_rnd[40] ? 32'hFFFF_FFFF : z_rnd[39:8];
      n16x <= nx_rnd[N_W:12];
      n16y <= ny_rnd[N_W:12];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      mx <= n16x * z;
      my <= n16y * z;
    end
  end

  assign mx_rnd    = {1'b0, mx} + (M_W+1)'(32768);
  assign my_rnd    = {1'b0, my} + (M_W+1)'(32768);
  assign has_depth = depth_q != 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      // drop items with no depth unless they close the frame
      out_valid <= has_depth || flast_q;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // with zero depth z is zero, so x and y come out zero as well
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      point_valid <= has_depth;
      frame_end   <= flast_q;
      x_q16       <= sat_axis(mx_rnd[M_W:16], negx);
      y_q16       <= sat_axis(my_rnd[M_W:16], negy);
      z_q16       <= z;
      point_blue  <= has_depth ? blue_q : 8'd0;
      point_green <= has_depth ? green_q : 8'd0;
      point_red   <= has_depth ? red_q : 8'd0;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

@@ sv/depth_to_point_backprojection.sv @@
// Depth-to-point back-projection. Each accepted pixel (depth plus colour)
// passes through capture, depth/offset multiply, round, offset-times-z
// multiply and output load; one item is in flight at a time: the next pixel
// is taken after the output load, which waits for a free output register.
// Pixel position comes from internal column and row counters that wrap at
// the configured image size; configuration writes never touch them. A
// zero-depth pixel yields no item, except the last pixel of a frame, which
// always yields one with frame_end set. Configuration is to be written only
// while the block is idle; cfg_ready is always high, so it is not enforced.
module depth_to_point_backprojection #(
  parameter int MAX_DIMENSION = dbp_pkg::MAX_DIMENSION_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [15:0]                         depth_raw,
  input  logic [7:0]                          blue,
  input  logic [7:0]                          green,
  input  logic [7:0]                          red,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                point_valid,
  output logic                                frame_end,
  output logic signed [31:0]                  x_q16,
  output logic signed [31:0]                  y_q16,
  output logic [31:0]                         z_q16,
  output logic [7:0]                          point_blue,
  output logic [7:0]                          point_green,
  output logic [7:0]                          point_red,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dbp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dbp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dbp_pkg::*;

  logic [12:0] image_cols, image_rows;
  logic [15:0] center_x_q4, center_y_q4;
  logic [23:0] inv_focal_x_q24, inv_focal_y_q24, metres_per_unit_q24;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_cols          <= RST_IMAGE_COLS;
      image_rows          <= RST_IMAGE_ROWS;
      center_x_q4         <= RST_CENTER_X;
      center_y_q4         <= RST_CENTER_Y;
      inv_focal_x_q24     <= RST_INV_FOCAL_X;
      inv_focal_y_q24     <= RST_INV_FOCAL_Y;
      metres_per_unit_q24 <= RST_METRES_PER_UNIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_COLS:      image_cols          <= cfg_data[12:0];
        REG_IMAGE_ROWS:      image_rows          <= cfg_data[12:0];
        REG_CENTER_X:        center_x_q4         <= cfg_data[15:0];
        REG_CENTER_Y:        center_y_q4         <= cfg_data[15:0];
        REG_INV_FOCAL_X:     inv_focal_x_q24     <= cfg_data;
        REG_INV_FOCAL_Y:     inv_focal_y_q24     <= cfg_data;
        REG_METRES_PER_UNIT: metres_per_unit_q24 <= cfg_data;
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  dbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dbp_datapath #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .depth_raw           (depth_raw),
    .blue                (blue),
    .green               (green),
    .red                 (red),
    .image_cols          (image_cols),
    .image_rows          (image_rows),
    .center_x_q4         (center_x_q4),
    .center_y_q4         (center_y_q4),
    .inv_focal_x_q24     (inv_focal_x_q24),
    .inv_focal_y_q24     (inv_focal_y_q24),
    .metres_per_unit_q24 (metres_per_unit_q24),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .point_valid         (point_valid),
    .frame_end           (frame_end),
    .x_q16               (x_q16),
    .y_q16               (y_q16),
    .z_q16               (z_q16),
    .point_blue          (point_blue),
    .point_green         (point_green),
    .point_red           (point_red)
  );

  // one item in flight: no second accept right after the first
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // an item without a point only marks the frame end and carries zeros
  a_marker_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !point_valid) |-> (frame_end && z_q16 == 32'd0 &&
      x_q16 == 32'sd0 && y_q16 == 32'sd0))
    else $error("frame-end marker carries nonzero payload");

  // zero distance puts the point on the optical axis
  a_zero_z: assert property (@(posedge clk) disable iff (rst)
    (out_valid && point_valid && z_q16 == 32'd0) |->
      (x_q16 == 32'sd0 && y_q16 == 32'sd0))
    else $error("nonzero x or y with zero z");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for depth_to_point_backprojection: pixel and point
// channels run with random stalls, and every point is checked against
// a fixed-point back-projection predictor kept in the bench. Needs dbp_pkg.
module tb_top;
  import dbp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int MAX_ERR_LINES = 40;

  typedef struct packed {
    logic [12:0] cols;
    logic [12:0] rows;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [23:0] fx;
    logic [23:0] fy;
    logic [23:0] mpu;
  } cam_cfg_t;

  typedef struct packed {
    logic        pv;
    logic        fe;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [7:0]  b;
    logic [7:0]  g;
    logic [7:0]  r;
  } point_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] depth_raw = '0;
  logic [7:0] blue = '0;
  logic [7:0] green = '0;
  logic [7:0] red = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic point_valid;
  logic frame_end;
  logic signed [31:0] x_q16;
  logic signed [31:0] y_q16;
  logic [31:0] z_q16;
  logic [7:0] point_blue;
  logic [7:0] point_green;
  logic [7:0] point_red;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cam_cfg_t cam;
  logic [11:0] col_pos;
  logic [11:0] row_pos;
  point_t expected_points[$];
  int err_count = 0;
  int cycle_count = 0;
  int rx_hold = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;

  depth_to_point_backprojection i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .depth_raw   (depth_raw),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_valid (point_valid),
    .frame_end   (frame_end),
    .x_q16       (x_q16),
    .y_q16       (y_q16),
    .z_q16       (z_q16),
    .point_blue  (point_blue),
    .point_green (point_green),
    .point_red   (point_red),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------- prediction ----------------

  function automatic logic [12:0] clamp_dim(input logic [12:0] v);
    logic [12:0] max_dim;
    max_dim = 13'(MAX_DIMENSION_DEF);
    if (v == 13'd0) return 13'd1;
    if (v > max_dim) return max_dim;
    return v;
  endfunction

  // Centred offset times z over the focal length, rounded half away from zero.
  function automatic logic [31:0] backproject(input logic [11:0] pos, input logic [15:0] c,
                                              input logic [23:0] inv, input logic [31:0] z);
    logic [63:0] p16, c64, d, n, n16, m, mag;
    logic neg;
    p16 = {48'd0, pos, 4'd0};
    c64 = {48'd0, c};
    neg = p16 < c64;
    d = neg ? c64 - p16 : p16 - c64;
    n = d * {40'd0, inv};
    n16 = (n + 64'd2048) >> 12;
    m = n16 * {32'd0, z};
    mag = (m + 64'd32768) >> 16;
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'd0 - mag[31:0];
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // Append one expected point at the tail of the queue.
  function automatic void queue_point(input point_t p);
    expected_points = {expected_points, p};
  endfunction

  function automatic void predict_point(input logic [15:0] depth, input logic [7:0] b,
                                        input logic [7:0] g, input logic [7:0] r);
    logic [12:0] cols, rows;
    logic row_end, last;
    logic [11:0] col, row;
    logic [63:0] zfull, zr;
    point_t p;
    cols = clamp_dim(cam.cols);
    rows = clamp_dim(cam.rows);
    row_end = {1'b0, col_pos} >= cols - 13'd1;
    last = row_end && ({1'b0, row_pos} >= rows - 13'd1);
    col = col_pos;
    row = row_pos;
    if (row_end) begin
      col_pos = '0;
      row_pos = last ? 12'd0 : row_pos + 12'd1;
    end else begin
      col_pos = col_pos + 12'd1;
    end
    p = '0;
    if (depth != 16'd0) begin
      zfull = {48'd0, depth} * {40'd0, cam.mpu};
      zr = (zfull + 64'd128) >> 8;
      p.z = (zr > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : zr[31:0];
      p.pv = 1'b1;
      p.fe = last;
      p.x = backproject(col, cam.cx, cam.fx, p.z);
      p.y = backproject(row, cam.cy, cam.fy, p.z);
      p.b = b;
      p.g = g;
      p.r = r;
      queue_point(p);
    end else if (last) begin
      // frame-end marker only, all payload zero
      p.fe = 1'b1;
      queue_point(p);
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_IMAGE_COLS:      cam.cols = data[12:0];
      REG_IMAGE_ROWS:      cam.rows = data[12:0];
      REG_CENTER_X:        cam.cx = data[15:0];
      REG_CENTER_Y:        cam.cy = data[15:0];
      REG_INV_FOCAL_X:     cam.fx = data;
      REG_INV_FOCAL_Y:     cam.fy = data;
      REG_METRES_PER_UNIT: cam.mpu = data;
      default: ;
    endcase
  endfunction

  // ---------------- checking ----------------

  task automatic report_error(input string msg);
    if (err_count < MAX_ERR_LINES) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_error($sformatf("%s got %h expected %h", name, got, want));
  endtask

  always @(posedge clk) begin : check_points
    point_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        report_error("point with no pending pixel");
      end else begin
        want = expected_points.pop_front();
        check_field("point_valid", 32'(point_valid), 32'(want.pv));
        check_field("frame_end", 32'(frame_end), 32'(want.fe));
        check_field("x_q16", x_q16, want.x);
        check_field("y_q16", y_q16, want.y);
        check_field("z_q16", z_q16, want.z);
        check_field("point_blue", 32'(point_blue), 32'(want.b));
        check_field("point_green", 32'(point_green), 32'(want.g));
        check_field("point_red", 32'(point_red), 32'(want.r));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------- stalls and channel tasks ----------------

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (rx_idle_en && $urandom_range(0, 4) == 0) rx_hold <= pick_gap();
    end
  end

  task automatic push_pixel(input logic [15:0] depth, input logic [7:0] b,
                            input logic [7:0] g, input logic [7:0] r);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 9) < 4) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    depth_raw <= depth;
    blue <= b;
    green <= g;
    red <= r;
    do @(posedge clk); while (!in_ready);
    predict_point(depth, b, g, r);
  endtask

  // Drop valid and hold until every pending point has come out.
  task automatic stop_sending();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_points.size() != 0);
  endtask

  // Zero-depth pixels give no point, so allow the pipeline to empty as well.
  task automatic settle();
    stop_sending();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    write_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // Write all registers with random junk above each register's width.
  task automatic configure(input cam_cfg_t s);
    logic [23:0] junk;
    settle();
    junk = 24'($urandom);
    write_reg(REG_IMAGE_COLS, {junk[10:0], s.cols});
    junk = 24'($urandom);
    write_reg(REG_IMAGE_ROWS, {junk[10:0], s.rows});
    junk = 24'($urandom);
    write_reg(REG_CENTER_X, {junk[7:0], s.cx});
    junk = 24'($urandom);
    write_reg(REG_CENTER_Y, {junk[7:0], s.cy});
    write_reg(REG_INV_FOCAL_X, s.fx);
    write_reg(REG_INV_FOCAL_Y, s.fy);
    write_reg(REG_METRES_PER_UNIT, s.mpu);
    if ($urandom_range(0, 3) == 0) begin
      junk = 24'($urandom);
      write_reg(REG_UNUSED, junk);
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------- tests ----------------

  task automatic test_reset_defaults();
    push_pixel(16'hFFFF, 8'hFF, 8'h00, 8'hAA);
    push_pixel(16'd1, 8'h00, 8'hFF, 8'h55);
    push_pixel(16'd0, 8'h12, 8'h34, 8'h56);
    push_pixel(16'd1000, 8'h80, 8'h7F, 8'h01);
  endtask

  task automatic test_frame_end_markers();
    cam_cfg_t s;
    s = cam;
    // a one-pixel frame ends on every pixel, which also puts the counters at zero
    s.cols = 13'd1;
    s.rows = 13'd1;
    configure(s);
    push_pixel(16'd0, 8'hFF, 8'hFF, 8'hFF);
    s.cols = 13'd2;
    s.rows = 13'd2;
    configure(s);
    push_pixel(16'd500, 8'h01, 8'h02, 8'h03);
    push_pixel(16'd0, 8'h04, 8'h05, 8'h06);
    push_pixel(16'd700, 8'h07, 8'h08, 8'h09);
    push_pixel(16'd0, 8'hAA, 8'hBB, 8'hCC);
    s.cols = 13'd1;
    s.rows = 13'd1;
    configure(s);
    push_pixel(16'd2000, 8'h55, 8'h66, 8'h77);
  endtask

  task automatic test_resize_mid_frame();
    cam_cfg_t s;
    s = cam;
    s.cols = 13'd8;
    s.rows = 13'd3;
    configure(s);
    for (int i = 0; i < 5; i++) push_pixel(16'd300 + 16'(i), 8'(i), 8'hF0, 8'h0F);
    // column counter is now past the new row length
    write_one(REG_IMAGE_COLS, 24'd2);
    push_pixel(16'd400, 8'h11, 8'h22, 8'h33);
    write_one(REG_IMAGE_ROWS, 24'd1);
    push_pixel(16'd450, 8'h44, 8'h55, 8'h66);
    push_pixel(16'd460, 8'h77, 8'h88, 8'h99);
  endtask

  task automatic test_extreme_values();
    cam_cfg_t s;
    s.cols = 13'h1FFF;
    s.rows = 13'd0;
    s.cx = 16'hFFFF;
    s.cy = 16'd0;
    s.fx = 24'hFFFFFF;
    s.fy = 24'hFFFFFF;
    s.mpu = 24'hFFFFFF;
    configure(s);
    push_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(16'hFFFF, 8'h00, 8'h00, 8'h00);
    s.cx = 16'd0;
    s.cy = 16'hFFFF;
    configure(s);
    push_pixel(16'hFFFF, 8'h5A, 8'hA5, 8'h3C);
    s.fx = 24'd0;
    s.fy = 24'd1;
    s.mpu = 24'd1;
    configure(s);
    write_one(REG_UNUSED, 24'hFFFFFF);
    push_pixel(16'd1, 8'hC3, 8'h3C, 8'h96);
    push_pixel(16'hFFFF, 8'h69, 8'h96, 8'hF0);
  endtask

  function automatic logic [12:0] pick_dim(input bit big);
    int r;
    r = $urandom_range(0, 99);
    if (big) return (r < 50) ? 13'(MAX_DIMENSION_DEF) : 13'h1FFF;
    if (r < 8) return 13'd0;
    if (r < 14) return 13'($urandom_range(MAX_DIMENSION_DEF + 1, 8191));
    if (r < 18) return 13'(MAX_DIMENSION_DEF);
    return 13'($urandom_range(1, 16));
  endfunction

  function automatic logic [15:0] pick_center(input logic [12:0] dim);
    int r, hi;
    r = $urandom_range(0, 99);
    if (r < 12) return 16'd0;
    if (r < 24) return 16'hFFFF;
    hi = clamp_dim(dim) * 16 + 64;
    if (hi > 65535) hi = 65535;
    return 16'($urandom_range(0, hi));
  endfunction

  function automatic logic [23:0] pick_gain();
    int r;
    logic [23:0] v;
    r = $urandom_range(0, 99);
    v = 24'($urandom);
    if (r < 8) return 24'hFFFFFF;
    if (r < 16) return 24'd1;
    if (r < 20) return 24'd0;
    if (r < 60) return 24'($urandom_range(16000, 40000));
    return v;
  endfunction

  task automatic test_random_frames(input int phases, input int per_phase);
    cam_cfg_t s;
    int r, hold_at;
    logic [15:0] depth;
    logic [23:0] pix;
    for (int p = 0; p < phases; p++) begin
      s.cols = pick_dim(p == 3);
      s.rows = pick_dim(1'b0);
      s.cx = pick_center(s.cols);
      s.cy = pick_center(s.rows);
      s.fx = pick_gain();
      s.fy = pick_gain();
      s.mpu = pick_gain();
      configure(s);
      // leave one side free-running in some phases
      tx_idle_en = (p % 4) != 1;
      rx_idle_en <= (p % 4) != 2;
      hold_at = (p % 3 == 0) ? int'($urandom_range(1, per_phase - 1)) : -1;
      for (int i = 0; i < per_phase; i++) begin
        if (i == hold_at) stop_sending();
        r = $urandom_range(0, 99);
        depth = 16'($urandom);
        if (r < 20) depth = 16'd0;
        else if (r < 25) depth = 16'hFFFF;
        else if (r < 32) depth = 16'($urandom_range(1, 255));
        pix = 24'($urandom);
        push_pixel(depth, pix[7:0], pix[15:8], pix[23:16]);
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  initial begin
    cam = {RST_IMAGE_COLS, RST_IMAGE_ROWS, RST_CENTER_X, RST_CENTER_Y,
           RST_INV_FOCAL_X, RST_INV_FOCAL_Y, RST_METRES_PER_UNIT};
    col_pos = '0;
    row_pos = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_frame_end_markers();
    test_resize_mid_frame();
    test_extreme_values();
    test_random_frames(8, 200);
    settle();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ depth_to_point_backprojection.f @@
sv/dbp_pkg.sv
sv/dbp_ctrl.sv
sv/dbp_datapath.sv
sv/depth_to_point_backprojection.sv
tb/sv/tb_top.sv
